@@ rtl/svm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_pkg
// Opcodes, status codes, controller states and command structs.
// ----------------------------------------------------------------------------
package svm_pkg;

    localparam logic [4:0] OP_EXIT    = 5'd0;
    localparam logic [4:0] OP_MOVI    = 5'd1;
    localparam logic [4:0] OP_ADD     = 5'd2;
    localparam logic [4:0] OP_MOV     = 5'd3;
    localparam logic [4:0] OP_SUB     = 5'd4;
    localparam logic [4:0] OP_MUL     = 5'd5;
    localparam logic [4:0] OP_DIV     = 5'd6;
    localparam logic [4:0] OP_INC     = 5'd7;
    localparam logic [4:0] OP_DEC     = 5'd8;
    localparam logic [4:0] OP_JMP     = 5'd9;
    localparam logic [4:0] OP_CMPEQ   = 5'd10;
    localparam logic [4:0] OP_CMPLT   = 5'd11;
    localparam logic [4:0] OP_JT      = 5'd12;
    localparam logic [4:0] OP_JNT     = 5'd13;
    localparam logic [4:0] OP_PUSH    = 5'd14;
    localparam logic [4:0] OP_POP     = 5'd15;
    localparam logic [4:0] OP_LOAD    = 5'd16;
    localparam logic [4:0] OP_STORE   = 5'd17;
    localparam logic [4:0] OP_LOADI   = 5'd18;
    localparam logic [4:0] OP_STOREI  = 5'd19;
    localparam logic [4:0] OP_LOADSC  = 5'd20;
    localparam logic [4:0] OP_STORESC = 5'd21;
    localparam logic [4:0] OP_PENUP   = 5'd22;
    localparam logic [4:0] OP_PENDOWN = 5'd23;
    localparam logic [4:0] OP_FWD     = 5'd24;
    localparam logic [4:0] OP_BACK    = 5'd25;

    localparam logic [2:0] ST_OK    = 3'd0;
    localparam logic [2:0] ST_HIGH  = 3'd1;
    localparam logic [2:0] ST_LOW   = 3'd2;
    localparam logic [2:0] ST_DIV0  = 3'd3;
    localparam logic [2:0] ST_STACK = 3'd4;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_ITER,
        S_MEMRD,
        S_MEMWB,
        S_DONE
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic latch;     // capture instruction and operands
        logic exec;      // execute / start multiply or divide
        logic iter;      // one multiply or divide step
        logic finish;    // write back multiply or divide result
        logic mem_wb;    // write back stack read data
    } dp_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic need_iter;
        logic need_mem;
        logic iter_last;
    } dp_stat_t;

endpackage

@@ rtl/stack_vm_instruction_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stack_vm_instruction_execute_unit
// Execute unit of a small register and stack machine.
// ----------------------------------------------------------------------------
// One instruction is taken per input transfer (in_valid / in_ready) and one
// result is given per output transfer (out_valid / out_ready).
// Instructions run one at a time; in_ready is high only while idle.
// From input transfer to result, an instruction passes through S_EXEC and
// S_DONE for register, flag, jump, move and stack-store instructions and for
// faults; through S_EXEC, S_MEMRD, S_MEMWB and S_DONE for in-range stack
// loads and pop (registered stack RAM read); through S_EXEC, the S_ITER
// steps and S_DONE for mul and div (one bit per cycle in the shift-add
// multiplier or restoring divider). out_valid is high in S_DONE.
// in_ready returns the cycle after the result transfers.
// The result holds while out_ready is low; no new instruction is taken
// until the result transfers. Reset clears registers, sc and both flags;
// stack words are undefined until written.
// ----------------------------------------------------------------------------
module stack_vm_instruction_execute_unit
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH  = 256,
    parameter int GENERAL_REGS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [4:0]         req_type,
    input  logic [3:0]         first_reg,
    input  logic [3:0]         second_reg,
    input  logic [3:0]         third_reg,
    input  logic signed [31:0] immediate,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               halt,
    output logic [2:0]         status,
    output logic               jump_taken,
    output logic signed [31:0] jump_target,
    output logic               test_flag,
    output logic               pen_down,
    output logic               move_valid,
    output logic signed [31:0] move_distance
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    svm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    svm_dp #(.STACK_DEPTH(STACK_DEPTH), .GENERAL_REGS(GENERAL_REGS)) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_type      (req_type),
        .first_reg     (first_reg),
        .second_reg    (second_reg),
        .third_reg     (third_reg),
        .immediate     (immediate),
        .halt          (halt),
        .status        (status),
        .jump_taken    (jump_taken),
        .jump_target   (jump_target),
        .test_flag     (test_flag),
        .pen_down      (pen_down),
        .move_valid    (move_valid),
        .move_distance (move_distance)
    );

endmodule

@@ rtl/svm_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module svm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[addr];
        end
    end

endmodule

@@ rtl/svm_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_ctrl
// Sequencer: accept, execute, iterate or stack read, then present result.
// ----------------------------------------------------------------------------
module svm_ctrl
    import svm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    output logic     out_valid,
    input  logic     out_ready,
    output dp_cmd_t  cmd,
    input  dp_stat_t stat
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (stat.need_iter)
                begin
                    state_next = S_ITER;
                end
                else if (stat.need_mem)
                begin
                    state_next = S_MEMRD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ITER:
            begin
                cmd.iter = 1'b1;
                if (stat.iter_last)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_DONE;
                end
            end
            S_MEMRD:
            begin
                state_next = S_MEMWB;
            end
            S_MEMWB:
            begin
                cmd.mem_wb = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/svm_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_dp
// Register file, flags, stack memory, shift-add multiplier, restoring divider.
// ----------------------------------------------------------------------------
module svm_dp
    import svm_pkg::*;
#(
    parameter int STACK_DEPTH  = 256,
    parameter int GENERAL_REGS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  dp_cmd_t            cmd,
    output dp_stat_t           stat,
    input  logic [4:0]         req_type,
    input  logic [3:0]         first_reg,
    input  logic [3:0]         second_reg,
    input  logic [3:0]         third_reg,
    input  logic signed [31:0] immediate,
    output logic               halt,
    output logic [2:0]         status,
    output logic               jump_taken,
    output logic signed [31:0] jump_target,
    output logic               test_flag,
    output logic               pen_down,
    output logic               move_valid,
    output logic signed [31:0] move_distance
);

    localparam int AW = $clog2(STACK_DEPTH);

    logic [31:0] rf_reg [GENERAL_REGS+1];
    logic        cmp_reg, pen_reg;

    logic [4:0]  op_reg;
    logic [3:0]  ra_reg;
    logic [31:0] imm_reg, a_reg, b_reg, c_reg, sc_reg;

    // result registers
    logic        halt_reg, jt_reg, mv_reg;
    logic [2:0]  st_reg;
    logic [31:0] jtg_reg, md_reg;

    // multiply / divide iteration
    logic [5:0]  cnt_reg;
    logic [63:0] acc_reg;   // mul: product; div: {rem, quotient}
    logic [31:0] mcand_reg, mplier_reg;
    logic        neg_reg;

    function automatic logic [31:0] rd(input logic [3:0] idx);
        logic [31:0] v;
        v = '0;
        for (int i = 0; i <= GENERAL_REGS; i++)
        begin
            if (idx == 4'(i))
            begin
                v = rf_reg[i];
            end
        end
        return v;
    endfunction

    // exact stack index, 34 bits signed
    logic signed [33:0] idx_s;
    logic               idx_ok, is_load, is_store;
    logic signed [33:0] sc_s, a_s, b_s;

    assign sc_s = 34'(signed'(sc_reg));
    assign a_s  = 34'(signed'(a_reg));
    assign b_s  = 34'(signed'(b_reg));

    always_comb
    begin
        idx_s    = '0;
        is_load  = 1'b0;
        is_store = 1'b0;
        case (op_reg)
            OP_PUSH:    begin idx_s = sc_s; is_store = 1'b1; end
            OP_POP:     begin idx_s = sc_s - 34'sd1; is_load = 1'b1; end
            OP_LOAD:    begin idx_s = b_s; is_load = 1'b1; end
            OP_LOADI:   begin idx_s = 34'(signed'(imm_reg)); is_load = 1'b1; end
            OP_LOADSC:  begin idx_s = sc_s - b_s - 34'sd1; is_load = 1'b1; end
            OP_STORE:   begin idx_s = a_s; is_store = 1'b1; end
            OP_STOREI:  begin idx_s = 34'(signed'(imm_reg)); is_store = 1'b1; end
            OP_STORESC: begin idx_s = sc_s - a_s - 34'sd1; is_store = 1'b1; end
            default:    ;
        endcase
        idx_ok = (idx_s >= 34'sd0) && (idx_s < 34'(STACK_DEPTH));
    end

    logic        ram_we, ram_re;
    logic [31:0] ram_wdata, ram_rdata;

    assign ram_we    = cmd.exec && is_store && idx_ok;
    assign ram_re    = cmd.exec && is_load && idx_ok;
    assign ram_wdata = (op_reg == OP_PUSH) ? a_reg : b_reg;

    svm_ram #(.WIDTH(32), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .re    (ram_re),
        .addr  (idx_s[AW-1:0]),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign stat.need_iter = (op_reg == OP_MUL) || ((op_reg == OP_DIV) && (c_reg != '0));
    assign stat.need_mem  = is_load && idx_ok;
    assign stat.iter_last = (cnt_reg == 6'd31);

    // overflow class of a 34-bit exact value
    function automatic logic [2:0] cls34(input logic signed [33:0] v);
        if (v > 34'sh0_7FFF_FFFF)
        begin
            return ST_HIGH;
        end
        if (v < -34'sh0_8000_0000)
        begin
            return ST_LOW;
        end
        return ST_OK;
    endfunction

    // magnitude product / quotient as signed 65-bit exact value
    logic signed [64:0] mag_s, res_s;
    logic [63:0]        mul_step;
    logic [32:0]        div_trial;
    logic [63:0]        div_step;

    always_comb
    begin
        mul_step  = acc_reg + (mplier_reg[cnt_reg[4:0]] ? (64'(mcand_reg) << cnt_reg[4:0])
                                                         : 64'd0);
        div_trial = {acc_reg[63:32], acc_reg[31]} - {1'b0, mcand_reg};
        if (!div_trial[32])
        begin
            div_step = {div_trial[31:0], acc_reg[30:0], 1'b1};
        end
        else
        begin
            div_step = {acc_reg[62:0], 1'b0};
        end
        if (op_reg == OP_MUL)
        begin
            mag_s = {1'b0, mul_step};
        end
        else
        begin
            mag_s = {33'd0, div_step[31:0]};
        end
        res_s = neg_reg ? -mag_s : mag_s;
    end

    logic signed [33:0] ar_x;
    logic               wr_en;
    logic [3:0]         wr_idx;
    logic [31:0]        wr_val, sc_new;
    logic               sc_wr;

    always_comb
    begin
        wr_en  = 1'b0;
        wr_idx = ra_reg;
        wr_val = '0;
        sc_wr  = 1'b0;
        sc_new = sc_reg;
        ar_x   = '0;
        if (cmd.exec)
        begin
            case (op_reg)
                OP_MOVI: begin wr_en = 1'b1; wr_val = imm_reg; end
                OP_MOV:  begin wr_en = 1'b1; wr_val = b_reg; end
                OP_ADD:  begin ar_x = b_s + 34'(signed'(c_reg)); wr_en = 1'b1; end
                OP_SUB:  begin ar_x = b_s - 34'(signed'(c_reg)); wr_en = 1'b1; end
                OP_INC:  begin ar_x = a_s + 34'sd1; wr_en = 1'b1; end
                OP_DEC:  begin ar_x = a_s - 34'sd1; wr_en = 1'b1; end
                OP_PUSH:
                begin
                    if (idx_ok)
                    begin
                        sc_wr = 1'b1; sc_new = sc_reg + 32'd1;
                    end
                end
                OP_POP:
                begin
                    if (idx_ok)
                    begin
                        sc_wr = 1'b1; sc_new = sc_reg - 32'd1;
                    end
                end
                default: ;
            endcase
            if (op_reg == OP_ADD || op_reg == OP_SUB || op_reg == OP_INC || op_reg == OP_DEC)
            begin
                wr_val = ar_x[31:0];
            end
        end
        else if (cmd.finish)
        begin
            wr_en  = 1'b1;
            wr_val = res_s[31:0];
        end
        else if (cmd.mem_wb)
        begin
            wr_en  = 1'b1;
            wr_val = ram_rdata;
        end
    end

    // result fields and operand magnitudes for the execute cycle
    logic        halt_next, jt_next, mv_next;
    logic [2:0]  st_next;
    logic [31:0] jtg_next, md_next, b_mag, c_mag;

    always_comb
    begin
        b_mag     = b_reg[31] ? -b_reg : b_reg;
        c_mag     = c_reg[31] ? -c_reg : c_reg;
        halt_next = (op_reg == OP_EXIT);
        jt_next   = 1'b0;
        jtg_next  = '0;
        mv_next   = 1'b0;
        md_next   = '0;
        st_next   = ST_OK;
        case (op_reg) inside
            OP_ADD, OP_SUB, OP_INC, OP_DEC: st_next = cls34(ar_x);
            OP_DIV:  if (c_reg == '0) st_next = ST_DIV0;
            OP_JMP:  begin jt_next = 1'b1; jtg_next = a_reg; end
            OP_JT:   if (cmp_reg) begin jt_next = 1'b1; jtg_next = a_reg; end
            OP_JNT:  if (!cmp_reg) begin jt_next = 1'b1; jtg_next = a_reg; end
            OP_FWD:  begin mv_next = 1'b1; md_next = a_reg; end
            OP_BACK: begin mv_next = 1'b1; md_next = 32'd0 - a_reg; end
            default: ;
        endcase
        if ((is_load || is_store) && !idx_ok)
        begin
            st_next = ST_STACK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= GENERAL_REGS; i++)
            begin
                rf_reg[i] <= '0;
            end
            cmp_reg <= 1'b0;
            pen_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i <= GENERAL_REGS; i++)
            begin
                if (wr_en && wr_idx == 4'(i))
                begin
                    rf_reg[i] <= wr_val;
                end
                else if (sc_wr && i == GENERAL_REGS)
                begin
                    rf_reg[i] <= sc_new;
                end
            end
            if (cmd.exec)
            begin
                case (op_reg)
                    OP_CMPEQ:   cmp_reg <= (a_reg == b_reg);
                    OP_CMPLT:   cmp_reg <= (signed'(a_reg) < signed'(b_reg));
                    OP_PENUP:   pen_reg <= 1'b0;
                    OP_PENDOWN: pen_reg <= 1'b1;
                    default:    ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= req_type;
            ra_reg  <= first_reg;
            imm_reg <= immediate;
            a_reg   <= rd(first_reg);
            b_reg   <= rd(second_reg);
            c_reg   <= rd(third_reg);
            sc_reg  <= rf_reg[GENERAL_REGS];
        end
        if (cmd.exec)
        begin
            halt_reg   <= halt_next;
            jt_reg     <= jt_next;
            jtg_reg    <= jtg_next;
            mv_reg     <= mv_next;
            md_reg     <= md_next;
            st_reg     <= st_next;
            cnt_reg    <= '0;
            neg_reg    <= b_reg[31] ^ c_reg[31];
            // div: dividend magnitude in low half, divisor magnitude as mcand
            mcand_reg  <= (op_reg == OP_DIV) ? c_mag : b_mag;
            mplier_reg <= c_mag;
            acc_reg    <= (op_reg == OP_DIV) ? {32'd0, b_mag} : 64'd0;
        end
        if (cmd.iter)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            acc_reg <= (op_reg == OP_MUL) ? mul_step : div_step;
        end
        if (cmd.finish)
        begin
            if (res_s > 65'sh0_7FFF_FFFF)
            begin
                st_reg <= ST_HIGH;
            end
            else if (res_s < -65'sh0_8000_0000)
            begin
                st_reg <= ST_LOW;
            end
        end
    end

    assign halt          = halt_reg;
    assign status        = st_reg;
    assign jump_taken    = jt_reg;
    assign jump_target   = jtg_reg;
    assign test_flag     = cmp_reg;
    assign pen_down      = pen_reg;
    assign move_valid    = mv_reg;
    assign move_distance = md_reg;

endmodule

@@ rtl/svm_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// svm_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
module svm_checker
    import svm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] status,
    input logic       move_valid,
    input logic       jump_taken
);

    // one instruction at a time
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("in_ready while result pending");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status))
        else $error("stalled result changed");

    a_noout: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !out_valid)
        else $error("result in cycle after transfer");

    a_excl_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !(move_valid && jump_taken) && status <= ST_STACK)
        else $error("bad result combination");

endmodule

bind stack_vm_instruction_execute_unit svm_checker u_svm_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .move_valid (move_valid),
    .jump_taken (jump_taken)
);

@@ tb/tb_stack_vm_instruction_execute_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stack_vm_instruction_execute_unit
// Self-checking bench for the stack machine execute unit. Directed
// instructions hit the arithmetic limits, flag and jump cases and stack
// faults; random instruction streams follow under varied idling of both
// channels. Every result transfer is checked against an in-bench model.
// ----------------------------------------------------------------------------
module tb_stack_vm_instruction_execute_unit;
    import svm_pkg::*;

    localparam int  DEPTH     = 256;
    localparam int  AW        = $clog2(DEPTH);
    localparam int  SC        = 8;
    localparam int  MAX_CYCLE = 2000000;
    localparam logic [31:0] I32_MAX = 32'h7fffffff;
    localparam logic [31:0] I32_MIN = 32'h80000000;

    typedef struct {
        logic        halt;
        logic [2:0]  status;
        logic        jump_taken;
        logic [31:0] jump_target;
        logic        test_flag;
        logic        pen_down;
        logic        move_valid;
        logic [31:0] move_distance;
    } exec_result_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [4:0]         req_type = '0;
    logic [3:0]         first_reg = '0;
    logic [3:0]         second_reg = '0;
    logic [3:0]         third_reg = '0;
    logic signed [31:0] immediate = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic               halt;
    logic [2:0]         status;
    logic               jump_taken;
    logic signed [31:0] jump_target;
    logic               test_flag;
    logic               pen_down;
    logic               move_valid;
    logic signed [31:0] move_distance;

    // machine state as the bench tracks it
    logic [31:0] vm_regs [0:SC];
    logic        vm_cmp;
    logic        vm_pen;
    logic [31:0] vm_stack [0:DEPTH-1];
    bit          vm_written [0:DEPTH-1];

    exec_result_t pending_results [$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;

    stack_vm_instruction_execute_unit uut (.*);

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLE)
        begin
            $display("FAIL stack_vm_instruction_execute_unit");
            $finish;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_idle_pct);

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want,
                 cycle_count);
    endtask

    // result checker
    always @(posedge clk)
    begin
        exec_result_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 0, 0);
            else
            begin
                e = pending_results.pop_front();
                if (halt !== e.halt) report_mismatch("halt", 32'(halt), 32'(e.halt));
                if (status !== e.status)
                    report_mismatch("status", 32'(status), 32'(e.status));
                if (jump_taken !== e.jump_taken)
                    report_mismatch("jump_taken", 32'(jump_taken), 32'(e.jump_taken));
                if (jump_target !== e.jump_target)
                    report_mismatch("jump_target", jump_target, e.jump_target);
                if (test_flag !== e.test_flag)
                    report_mismatch("test_flag", 32'(test_flag), 32'(e.test_flag));
                if (pen_down !== e.pen_down)
                    report_mismatch("pen_down", 32'(pen_down), 32'(e.pen_down));
                if (move_valid !== e.move_valid)
                    report_mismatch("move_valid", 32'(move_valid), 32'(e.move_valid));
                if (move_distance !== e.move_distance)
                    report_mismatch("move_distance", move_distance, e.move_distance);
            end
        end
    end

    function automatic logic [31:0] reg_read(input logic [3:0] idx);
        return (idx <= SC) ? vm_regs[idx] : 32'd0;
    endfunction

    function automatic void reg_write(input logic [3:0] idx, input logic [31:0] v);
        if (idx <= SC)
            vm_regs[idx] = v;
    endfunction

    function automatic logic [2:0] write_wrapped(input logic [3:0] idx, input longint exact);
        reg_write(idx, exact[31:0]);
        if (exact > longint'(32'sh7fffffff)) return ST_HIGH;
        if (exact < -longint'(64'd2147483648)) return ST_LOW;
        return ST_OK;
    endfunction

    function automatic bit stack_ok(input longint i);
        return i >= 0 && i < DEPTH;
    endfunction

    // stack index read by the instruction, or -1 when it reads none
    function automatic longint read_index(input logic [4:0] op, input logic [3:0] rb,
                                          input logic signed [31:0] imm);
        longint sc, b;
        sc = longint'($signed(vm_regs[SC]));
        b  = longint'($signed(reg_read(rb)));
        case (op)
            OP_POP:    return (sc >= 1 && sc <= DEPTH) ? sc - 1 : -1;
            OP_LOAD:   return b;
            OP_LOADI:  return longint'(imm);
            OP_LOADSC: return sc - b - 1;
            default:   return -1;
        endcase
    endfunction

    function automatic exec_result_t execute_instr(input logic [4:0] op,
        input logic [3:0] ra, input logic [3:0] rb, input logic [3:0] rc,
        input logic signed [31:0] imm);
        exec_result_t r;
        longint a, b, c, sc, idx;
        a  = longint'($signed(reg_read(ra)));
        b  = longint'($signed(reg_read(rb)));
        c  = longint'($signed(reg_read(rc)));
        sc = longint'($signed(vm_regs[SC]));
        r = '{default: '0};
        case (op) inside
            OP_EXIT:  r.halt = 1'b1;
            OP_MOVI:  reg_write(ra, imm);
            OP_ADD:   r.status = write_wrapped(ra, b + c);
            OP_MOV:   reg_write(ra, reg_read(rb));
            OP_SUB:   r.status = write_wrapped(ra, b - c);
            OP_MUL:   r.status = write_wrapped(ra, b * c);
            OP_DIV:
                if (c == 0) r.status = ST_DIV0;
                else r.status = write_wrapped(ra, b / c);
            OP_INC:   r.status = write_wrapped(ra, a + 1);
            OP_DEC:   r.status = write_wrapped(ra, a - 1);
            OP_JMP:   begin r.jump_taken = 1'b1; r.jump_target = reg_read(ra); end
            OP_CMPEQ: vm_cmp = (a == b);
            OP_CMPLT: vm_cmp = (a < b);
            OP_JT:    if (vm_cmp) begin r.jump_taken = 1'b1; r.jump_target = reg_read(ra); end
            OP_JNT:   if (!vm_cmp) begin r.jump_taken = 1'b1; r.jump_target = reg_read(ra); end
            OP_PUSH:
                if (!stack_ok(sc)) r.status = ST_STACK;
                else
                begin
                    vm_stack[AW'(sc)] = reg_read(ra);
                    vm_written[AW'(sc)] = 1'b1;
                    vm_regs[SC] = 32'(sc + 1);
                end
            OP_POP:
                if (sc < 1 || sc > DEPTH) r.status = ST_STACK;
                else
                begin
                    vm_regs[SC] = 32'(sc - 1);
                    reg_write(ra, vm_stack[AW'(sc - 1)]);
                end
            OP_LOAD, OP_LOADI, OP_LOADSC:
            begin
                idx = read_index(op, rb, imm);
                if (!stack_ok(idx)) r.status = ST_STACK;
                else reg_write(ra, vm_stack[AW'(idx)]);
            end
            OP_STORE, OP_STOREI, OP_STORESC:
            begin
                idx = (op == OP_STORE) ? a : (op == OP_STOREI) ? longint'(imm) : sc - a - 1;
                if (!stack_ok(idx)) r.status = ST_STACK;
                else
                begin
                    vm_stack[AW'(idx)] = reg_read(rb);
                    vm_written[AW'(idx)] = 1'b1;
                end
            end
            OP_PENUP:   vm_pen = 1'b0;
            OP_PENDOWN: vm_pen = 1'b1;
            OP_FWD:  begin r.move_valid = 1'b1; r.move_distance = reg_read(ra); end
            OP_BACK: begin r.move_valid = 1'b1; r.move_distance = 32'd0 - reg_read(ra); end
            default: ;
        endcase
        r.test_flag = vm_cmp;
        r.pen_down  = vm_pen;
        return r;
    endfunction

    task automatic send_instr(input logic [4:0] op, input logic [3:0] ra,
                              input logic [3:0] rb, input logic [3:0] rc,
                              input logic signed [31:0] imm);
        int gap;
        longint ridx;
        // never read a stack word that has not been written: send a store to it instead
        ridx = read_index(op, rb, imm);
        if (stack_ok(ridx) && !vm_written[AW'(ridx)])
        begin
            op  = OP_STOREI;
            imm = 32'(ridx);
        end
        gap = 0;
        if (send_idle_pct > 0)
            while ($urandom_range(99) < send_idle_pct && gap < 20) gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        req_type   <= op;
        first_reg  <= ra;
        second_reg <= rb;
        third_reg  <= rc;
        immediate  <= imm;
        do @(posedge clk); while (!in_ready);
        pending_results.push_back(execute_instr(op, ra, rb, rc, imm));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
    endtask

    task automatic test_arith_limits();
        send_instr(OP_MOVI, 0, 0, 0, I32_MAX);
        send_instr(OP_MOVI, 1, 0, 0, I32_MIN);
        send_instr(OP_MOVI, 2, 0, 0, -1);
        send_instr(OP_ADD, 3, 0, 0, 0);          // positive overflow
        send_instr(OP_SUB, 3, 1, 0, 0);          // negative overflow
        send_instr(OP_MUL, 4, 1, 1, 0);
        send_instr(OP_DIV, 4, 1, 2, 0);          // min / -1
        send_instr(OP_DIV, 4, 0, 7, 0);          // divide by zero
        send_instr(OP_INC, 0, 0, 0, 0);
        send_instr(OP_DEC, 1, 0, 0, 0);
        send_instr(OP_MOV, 5, 15, 0, 0);         // index past sc reads zero
        send_instr(OP_MOVI, 12, 0, 0, 5);        // write past sc is dropped
    endtask

    task automatic test_flow_and_pen();
        send_instr(OP_CMPEQ, 5, 6, 0, 0);
        send_instr(OP_JT, 0, 0, 0, 0);
        send_instr(OP_CMPLT, 0, 1, 0, 0);
        send_instr(OP_JNT, 2, 0, 0, 0);
        send_instr(OP_JMP, 1, 0, 0, 0);
        send_instr(OP_PENDOWN, 0, 0, 0, 0);
        send_instr(OP_BACK, 0, 0, 0, 0);         // back of min wraps
        send_instr(OP_FWD, 2, 0, 0, 0);
        send_instr(OP_PENUP, 0, 0, 0, 0);
        send_instr(5'd27, 0, 0, 0, 0);
        send_instr(5'd31, 15, 15, 15, -1);
        send_instr(OP_EXIT, 0, 0, 0, 0);
    endtask

    task automatic test_stack_faults();
        send_instr(OP_POP, 0, 0, 0, 0);          // empty stack
        send_instr(OP_PUSH, 2, 0, 0, 0);
        send_instr(OP_LOADSC, 6, 8, 0, 0);
        send_instr(OP_STORESC, 7, 2, 0, 0);
        send_instr(OP_LOADI, 3, 0, 0, I32_MIN);
        send_instr(OP_STOREI, 0, 2, 0, DEPTH);
        send_instr(OP_STOREI, 0, 0, 0, DEPTH - 1);
        send_instr(OP_MOVI, 4'(SC), 0, 0, DEPTH);
        send_instr(OP_PUSH, 0, 0, 0, 0);         // full stack
        send_instr(OP_POP, 9, 0, 0, 0);
        send_instr(OP_POP, 4'(SC), 0, 0, 0);     // pop into sc
    endtask

    task automatic test_random_stream(input int n, input int sp, input int rp,
                                      input bit pause);
        logic [4:0] op;
        logic [3:0] ra, rb, rc;
        logic signed [31:0] imm;
        send_idle_pct = sp;
        recv_idle_pct = rp;
        for (int i = 0; i < n; i++)
        begin
            if (pause && i == n / 2)
                wait_drained();
            op = ($urandom_range(99) < 5) ? 5'($urandom_range(26, 31))
                                          : 5'($urandom_range(0, 25));
            ra = ($urandom_range(99) < 8) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
            rb = ($urandom_range(99) < 8) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
            rc = ($urandom_range(99) < 8) ? 4'($urandom_range(9, 15))
                                          : 4'($urandom_range(0, 8));
            case ($urandom_range(5))
                0:       imm = $urandom;
                1:       imm = ($urandom_range(1)) ? I32_MAX : I32_MIN;
                2:       imm = -$signed(32'($urandom_range(300)));
                default: imm = $urandom_range(DEPTH + 4);
            endcase
            // keep sc mostly inside the stack so pushes and pops land
            if ($urandom_range(99) < 4)
                send_instr(OP_MOVI, 4'(SC), 0, 0, $urandom_range(DEPTH));
            send_instr(op, ra, rb, rc, imm);
        end
        wait_drained();
    endtask

    initial
    begin
        for (int i = 0; i <= SC; i++) vm_regs[i] = '0;
        for (int i = 0; i < DEPTH; i++) vm_written[i] = 1'b0;
        vm_cmp = 1'b0;
        vm_pen = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_arith_limits();
        test_flow_and_pen();
        test_stack_faults();
        wait_drained();
        test_random_stream(480, 30, 56, 1'b0);
        test_random_stream(480, 56, 30, 1'b1);
        test_random_stream(480, 0, 0, 1'b0);
        repeat (60) @(posedge clk);
        if (error_count == 0)
            $display("PASS stack_vm_instruction_execute_unit");
        else
            $display("FAIL stack_vm_instruction_execute_unit");
        $finish;
    end

endmodule
